[rtl/grouped_mean_stddev_core_defines.svh]
// Assertion helpers used by the RTL (gms_back).
`ifndef GROUPED_MEAN_STDDEV_CORE_DEFINES_SVH
`define GROUPED_MEAN_STDDEV_CORE_DEFINES_SVH

// same-cycle implication
`define GMS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gms_pkg.sv]
package gms_pkg;

  localparam int MaxGroupDef     = 4096;
  localparam int ResponseBitsDef = 16;
  localparam int DoseW           = 32;
  localparam int CountOutW       = 13;
  localparam int MeanW           = 16;
  localparam int StdW            = 16;
  localparam int FifoDepth       = 4;
  localparam int FifoPtrW        = 2;
  localparam int FifoCntW        = 3;

  typedef struct packed {
    logic not_empty;
    logic room2;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MEAN,
    ST_MULA,
    ST_MULB,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } gms_state_e;

endpackage

[rtl/gms_fifo.sv]
module gms_fifo #(
  parameter int Width = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_n_i,
  input  logic [Width-1:0]       wdata0_i,
  input  logic [Width-1:0]       wdata1_i,
  input  logic                   pop_i,
  output logic [Width-1:0]       rdata_o,
  output gms_pkg::fifo_stat_t    stat_o
);

  logic [Width-1:0]                 mem_q [gms_pkg::FifoDepth];
  logic [gms_pkg::FifoPtrW-1:0]     head_q, tail_q, tail_p1;
  logic [gms_pkg::FifoCntW-1:0]     cnt_q;

  assign tail_p1 = tail_q + gms_pkg::FifoPtrW'(1);
  assign rdata_o = mem_q[head_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.room2 = (cnt_q <= gms_pkg::FifoCntW'(gms_pkg::FifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[tail_q] <= wdata0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[tail_p1] <= wdata1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      tail_q <= tail_q + gms_pkg::FifoPtrW'(push_n_i);
      if (pop_i) begin
        head_q <= head_q + gms_pkg::FifoPtrW'(1);
      end
      cnt_q <= cnt_q + gms_pkg::FifoCntW'(push_n_i) - gms_pkg::FifoCntW'(pop_i);
    end
  end

endmodule

[rtl/gms_front.sv]
module gms_front #(
  parameter int MAX_GROUP     = gms_pkg::MaxGroupDef,
  parameter int RESPONSE_BITS = gms_pkg::ResponseBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [gms_pkg::DoseW-1:0]         dose_i,
  input  logic signed [RESPONSE_BITS-1:0]   response_i,
  input  logic                              last_item_i,
  input  gms_pkg::fifo_stat_t               stat_i,
  output logic [1:0]                        push_n_o,
  output logic [gms_pkg::DoseW+$clog2(MAX_GROUP+1)*3+RESPONSE_BITS*3+1:0] wdata0_o,
  output logic [gms_pkg::DoseW+$clog2(MAX_GROUP+1)*3+RESPONSE_BITS*3+1:0] wdata1_o
);

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int RB = RESPONSE_BITS;
  localparam int SW = RB + CW;
  localparam int QW = 2 * RB + CW;

  logic [gms_pkg::DoseW-1:0]  dose_q;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic signed [SW-1:0]       sum_q, sum_d;
  logic [QW-1:0]              sq_q, sq_d;
  logic                       open_q, ovf_q, ovf_d;
  logic signed [2*RB-1:0]     rsq;
  logic                       same, add_ok, acc, emit_a, emit_b;

  assign full   = !stat_i.room2;
  assign acc    = push && !full;
  assign rsq    = response_i * response_i;
  assign same   = open_q && (dose_i == dose_q);
  assign add_ok = cnt_q < CW'(MAX_GROUP);

  always_comb begin
    if (same) begin
      cnt_d = add_ok ? cnt_q + CW'(1) : cnt_q;
      sum_d = add_ok ? sum_q + SW'(response_i) : sum_q;
      sq_d  = add_ok ? sq_q + QW'($unsigned(rsq)) : sq_q;
      ovf_d = ovf_q | !add_ok;
    end else begin
      cnt_d = CW'(1);
      sum_d = SW'(response_i);
      sq_d  = QW'($unsigned(rsq));
      ovf_d = 1'b0;
    end
  end

  assign emit_a   = acc && open_q && !same;
  assign emit_b   = acc && last_item_i;
  assign push_n_o = 2'(emit_a) + 2'(emit_b);
  assign wdata1_o = {dose_i, cnt_d, sum_d, sq_d, ovf_d, 1'b1};
  assign wdata0_o = emit_a ? {dose_q, cnt_q, sum_q, sq_q, ovf_q, 1'b0} : wdata1_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dose_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      open_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (acc) begin
      if (last_item_i) begin
        dose_q <= '0;
        cnt_q  <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
        open_q <= 1'b0;
        ovf_q  <= 1'b0;
      end else begin
        dose_q <= dose_i;
        cnt_q  <= cnt_d;
        sum_q  <= sum_d;
        sq_q   <= sq_d;
        open_q <= 1'b1;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

[rtl/gms_back.sv]
`include "grouped_mean_stddev_core_defines.svh"

module gms_back #(
  parameter int MAX_GROUP     = gms_pkg::MaxGroupDef,
  parameter int RESPONSE_BITS = gms_pkg::ResponseBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gms_pkg::fifo_stat_t                  stat_i,
  input  logic [gms_pkg::DoseW+$clog2(MAX_GROUP+1)*3+RESPONSE_BITS*3+1:0] rec_i,
  output logic                                 fifo_pop_o,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [gms_pkg::DoseW-1:0]            group_dose_o,
  output logic [gms_pkg::CountOutW-1:0]        group_count_o,
  output logic signed [gms_pkg::MeanW-1:0]     group_mean_o,
  output logic [gms_pkg::StdW-1:0]             group_std_dev_o,
  output logic                                 std_valid_o,
  output logic                                 count_overflow_o,
  output logic                                 last_group_o
);

  localparam int CW  = $clog2(MAX_GROUP + 1);
  localparam int RB  = RESPONSE_BITS;
  localparam int SW  = RB + CW;
  localparam int QW  = 2 * RB + CW;
  localparam int NW  = 2 * RB + 2 * CW;
  localparam int DW  = 2 * CW;
  localparam int QXW = (NW > 32) ? NW : 33;
  localparam int ITW = $clog2(NW + 1);
  localparam int CXW = (CW > gms_pkg::CountOutW) ? CW : gms_pkg::CountOutW;
  localparam int MXW = (SW > 17) ? SW : 17;

  gms_pkg::gms_state_e state_q, state_d;

  logic [ITW-1:0]             it_q;
  logic [gms_pkg::DoseW-1:0]  dose_r_q;
  logic [CW-1:0]              n_q;
  logic                       sgn_q, ovf_r_q, last_r_q, big_q;
  logic [SW-1:0]              mag_q, md_q;
  logic [QW-1:0]              s2_q;
  logic [DW-1:0]              d_q;
  logic [CW-1:0]              mr_q;
  logic signed [NW:0]         acc_q, acc_nxt;
  logic [NW-1:0]              ms_q, dn_q;
  logic [SW-1:0]              mp_q;
  logic [DW-1:0]              dr_q;
  logic [QXW-1:0]             qd_q, qd_nxt;
  logic [DW-1:0]              dr_nxt;
  logic [31:0]                sx_q, sr_q, sb_q;
  logic                       ovalid_q, std_valid_q, out_load, last_it;

  logic [CW:0]                mtrial;
  logic [DW:0]                dtrial;
  logic [32:0]                stest;
  logic signed [SW-1:0]       rec_sum;
  logic [CXW-1:0]             n_x;
  logic [MXW-1:0]             q_x;
  logic [gms_pkg::CountOutW-1:0] count_q;

  assign rec_sum = rec_i[QW+2 +: SW];
  assign last_it = (it_q == ITW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gms_pkg::ST_IDLE: if (stat_i.not_empty) state_d = gms_pkg::ST_LOAD;
      gms_pkg::ST_LOAD: state_d = gms_pkg::ST_MEAN;
      gms_pkg::ST_MEAN: begin
        if (last_it) state_d = (n_q < CW'(2)) ? gms_pkg::ST_DONE : gms_pkg::ST_MULA;
      end
      gms_pkg::ST_MULA: if (last_it) state_d = gms_pkg::ST_MULB;
      gms_pkg::ST_MULB: if (last_it) state_d = gms_pkg::ST_DIV;
      gms_pkg::ST_DIV: begin
        if (last_it) begin
          state_d = (qd_nxt[QXW-1:32] != '0) ? gms_pkg::ST_DONE : gms_pkg::ST_SQRT;
        end
      end
      gms_pkg::ST_SQRT: if (last_it) state_d = gms_pkg::ST_DONE;
      gms_pkg::ST_DONE: if (!ovalid_q || pop) state_d = gms_pkg::ST_IDLE;
      default: state_d = gms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fifo_pop_o = (state_q == gms_pkg::ST_IDLE) && stat_i.not_empty;
    out_load   = (state_q == gms_pkg::ST_DONE) && (!ovalid_q || pop);
  end

  always_comb begin
    acc_nxt = acc_q;
    if (mp_q[0]) begin
      if (state_q == gms_pkg::ST_MULB) begin
        acc_nxt = acc_q - $signed({1'b0, ms_q});
      end else begin
        acc_nxt = acc_q + $signed({1'b0, ms_q});
      end
    end
  end

  assign mtrial = {mr_q, md_q[SW-1]};
  assign dtrial = {dr_q, dn_q[NW-1]};
  assign stest  = {1'b0, sr_q} + {1'b0, sb_q};

  always_comb begin
    if (dtrial >= {1'b0, d_q}) begin
      dr_nxt = DW'(dtrial - {1'b0, d_q});
      qd_nxt = {qd_q[QXW-2:0], 1'b1};
    end else begin
      dr_nxt = dtrial[DW-1:0];
      qd_nxt = {qd_q[QXW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gms_pkg::ST_IDLE: begin
        dose_r_q <= rec_i[SW+QW+CW+2 +: gms_pkg::DoseW];
        n_q      <= rec_i[SW+QW+2 +: CW];
        sgn_q    <= rec_sum[SW-1];
        mag_q    <= rec_sum[SW-1] ? SW'(-rec_sum) : SW'(rec_sum);
        s2_q     <= rec_i[2 +: QW];
        ovf_r_q  <= rec_i[1];
        last_r_q <= rec_i[0];
      end
      gms_pkg::ST_LOAD: begin
        d_q  <= DW'(n_q) * DW'(n_q - CW'(1));
        md_q <= mag_q;
        mr_q <= '0;
        it_q <= ITW'(SW);
      end
      gms_pkg::ST_MEAN: begin
        if (mtrial >= {1'b0, n_q}) begin
          mr_q <= CW'(mtrial - {1'b0, n_q});
          md_q <= {md_q[SW-2:0], 1'b1};
        end else begin
          mr_q <= mtrial[CW-1:0];
          md_q <= {md_q[SW-2:0], 1'b0};
        end
        it_q <= it_q - ITW'(1);
        if (last_it) begin
          acc_q <= '0;
          ms_q  <= NW'(s2_q);
          mp_q  <= SW'(n_q);
          it_q  <= ITW'(CW);
        end
      end
      gms_pkg::ST_MULA, gms_pkg::ST_MULB: begin
        acc_q <= acc_nxt;
        ms_q  <= {ms_q[NW-2:0], 1'b0};
        mp_q  <= {1'b0, mp_q[SW-1:1]};
        it_q  <= it_q - ITW'(1);
        if (last_it && state_q == gms_pkg::ST_MULA) begin
          ms_q <= NW'(mag_q);
          mp_q <= mag_q;
          it_q <= ITW'(SW);
        end
        if (last_it && state_q == gms_pkg::ST_MULB) begin
          dn_q <= acc_nxt[NW] ? '0 : acc_nxt[NW-1:0];
          dr_q <= '0;
          qd_q <= '0;
          it_q <= ITW'(NW);
        end
      end
      gms_pkg::ST_DIV: begin
        dn_q <= {dn_q[NW-2:0], 1'b0};
        dr_q <= dr_nxt;
        qd_q <= qd_nxt;
        it_q <= it_q - ITW'(1);
        if (last_it) begin
          big_q <= (qd_nxt[QXW-1:32] != '0);
          sx_q  <= qd_nxt[31:0];
          sr_q  <= '0;
          sb_q  <= 32'h4000_0000;
          it_q  <= ITW'(16);
        end
      end
      gms_pkg::ST_SQRT: begin
        if ({1'b0, sx_q} >= stest) begin
          sx_q <= sx_q - stest[31:0];
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
        it_q <= it_q - ITW'(1);
      end
      gms_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign n_x = CXW'(n_q);
  assign q_x = MXW'(md_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      group_dose_o <= dose_r_q;
      count_q <= (n_x > CXW'(8191)) ? 13'h1FFF : n_x[gms_pkg::CountOutW-1:0];
      if (sgn_q) begin
        group_mean_o <= (q_x > MXW'(32768)) ? 16'sh8000 : 16'(-q_x);
      end else begin
        group_mean_o <= (q_x > MXW'(32767)) ? 16'sh7FFF : q_x[15:0];
      end
      if (n_q < CW'(2)) begin
        group_std_dev_o <= '0;
        std_valid_q     <= 1'b0;
      end else begin
        group_std_dev_o <= big_q ? 16'hFFFF : sr_q[15:0];
        std_valid_q     <= 1'b1;
      end
      count_overflow_o <= ovf_r_q;
      last_group_o     <= last_r_q;
    end
  end

  assign group_count_o = count_q;
  assign std_valid_o   = std_valid_q;
  assign empty         = !ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gms_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (pop) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  `GMS_ASSERT(a_std_valid_multi, ovalid_q && std_valid_q, count_q >= 13'd2, "std valid on single item group")
  `GMS_ASSERT_NXT(a_pop_loads, fifo_pop_o, state_q == gms_pkg::ST_LOAD, "request taken without load")
  `GMS_ASSERT(a_sqrt_fits, state_q == gms_pkg::ST_SQRT, qd_q[QXW-1:32] == '0, "root operand too wide")

endmodule

[rtl/grouped_mean_stddev_core.sv]
// Observations are accepted one per cycle while the group queue has room for two records.
// Each finished group is handled by the back end one at a time, through bit-serial divides,
// multiplies and a square root; further records wait in the group queue meanwhile.
// Asynchronous active-low reset clears the accumulators, the queue and the result valid flag.
module grouped_mean_stddev_core #(
  parameter int MAX_GROUP     = gms_pkg::MaxGroupDef,
  parameter int RESPONSE_BITS = gms_pkg::ResponseBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [gms_pkg::DoseW-1:0]            dose_i,
  input  logic signed [RESPONSE_BITS-1:0]      response_i,
  input  logic                                 last_item_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [gms_pkg::DoseW-1:0]            group_dose_o,
  output logic [gms_pkg::CountOutW-1:0]        group_count_o,
  output logic signed [gms_pkg::MeanW-1:0]     group_mean_o,
  output logic [gms_pkg::StdW-1:0]             group_std_dev_o,
  output logic                                 std_valid_o,
  output logic                                 count_overflow_o,
  output logic                                 last_group_o
);

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int RW = gms_pkg::DoseW + 3 * CW + 3 * RESPONSE_BITS + 2;

  gms_pkg::fifo_stat_t stat;
  logic [1:0]          push_n;
  logic [RW-1:0]       wdata0, wdata1, rdata;
  logic                fifo_pop;

  gms_front #(
    .MAX_GROUP     (MAX_GROUP),
    .RESPONSE_BITS (RESPONSE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .dose_i      (dose_i),
    .response_i  (response_i),
    .last_item_i (last_item_i),
    .stat_i      (stat),
    .push_n_o    (push_n),
    .wdata0_o    (wdata0),
    .wdata1_o    (wdata1)
  );

  gms_fifo #(
    .Width (RW)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .wdata0_i (wdata0),
    .wdata1_i (wdata1),
    .pop_i    (fifo_pop),
    .rdata_o  (rdata),
    .stat_o   (stat)
  );

  gms_back #(
    .MAX_GROUP     (MAX_GROUP),
    .RESPONSE_BITS (RESPONSE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stat_i           (stat),
    .rec_i            (rdata),
    .fifo_pop_o       (fifo_pop),
    .empty            (empty),
    .pop              (pop),
    .group_dose_o     (group_dose_o),
    .group_count_o    (group_count_o),
    .group_mean_o     (group_mean_o),
    .group_std_dev_o  (group_std_dev_o),
    .std_valid_o      (std_valid_o),
    .count_overflow_o (count_overflow_o),
    .last_group_o     (last_group_o)
  );

endmodule

[test/tb_grouped_mean_stddev_core.sv]
module tb_grouped_mean_stddev_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxGroup = gms_pkg::MaxGroupDef;
  localparam int RespW    = gms_pkg::ResponseBitsDef;

  typedef struct packed {
    logic [gms_pkg::DoseW-1:0]     dose;
    logic [gms_pkg::CountOutW-1:0] count;
    logic [gms_pkg::MeanW-1:0]     mean;
    logic [gms_pkg::StdW-1:0]      std_dev;
    logic                          std_valid;
    logic                          overflow;
    logic                          last;
  } group_stat_t;

  typedef struct {
    logic [31:0]      dose;
    logic [RespW-1:0] resp;
    logic             last;
    logic             typed;
    group_stat_t      stat;
  } obs_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [gms_pkg::DoseW-1:0] dose_i = '0;
  logic signed [RespW-1:0] response_i = '0;
  logic last_item_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [gms_pkg::DoseW-1:0] group_dose_o;
  logic [gms_pkg::CountOutW-1:0] group_count_o;
  logic signed [gms_pkg::MeanW-1:0] group_mean_o;
  logic [gms_pkg::StdW-1:0] group_std_dev_o;
  logic std_valid_o, count_overflow_o, last_group_o;

  always #2 clk_i = ~clk_i;

  grouped_mean_stddev_core i_dut (.*);

  // group accumulator
  logic [31:0]     acc_dose;
  int unsigned     acc_n;
  longint          acc_sum;
  longint unsigned acc_sq;
  bit              acc_open, acc_ovf;

  group_stat_t stat_q[$];
  int  errors = 0;
  bit  tx_burst = 0, rx_burst = 0;

  function automatic logic [15:0] std_of(int unsigned n, longint s1, longint unsigned s2);
    logic [127:0] a, b, v;
    longint unsigned mag, x, res, bv;
    mag = s1 < 0 ? -s1 : s1;
    a = 128'(n) * 128'(s2);
    b = 128'(mag) * 128'(mag);
    if (a < b) return '0;
    v = (a - b) / 128'(n * (n - 1));
    x = (v[127:64] != 0) ? '1 : v[63:0];
    res = 0;
    bv = 64'd1 << 62;
    while (bv > x) bv >>= 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x -= res + bv;
        res = (res >> 1) + bv;
      end else begin
        res >>= 1;
      end
      bv >>= 2;
    end
    return res > 65535 ? 16'hffff : res[15:0];
  endfunction

  function automatic group_stat_t close_group(bit last);
    group_stat_t s;
    longint m;
    m = acc_sum / longint'(acc_n);
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    s.dose = acc_dose;
    s.count = acc_n > 8191 ? 13'h1fff : acc_n[12:0];
    s.mean = m[15:0];
    s.std_dev = acc_n >= 2 ? std_of(acc_n, acc_sum, acc_sq) : '0;
    s.std_valid = acc_n >= 2;
    s.overflow = acc_ovf;
    s.last = last;
    return s;
  endfunction

  function automatic void add_obs(logic [RespW-1:0] resp);
    longint r;
    r = longint'(signed'(resp));
    if (acc_n < MaxGroup) begin
      acc_n++;
      acc_sum += r;
      acc_sq += longint'(r * r);
    end else begin
      acc_ovf = 1;
    end
  endfunction

  // returns number of results added to stat_q
  function automatic int predict(logic [31:0] d, logic [RespW-1:0] resp, logic last);
    int k = 0;
    if (acc_open && d != acc_dose) begin
      stat_q.push_back(close_group(0));
      k++;
    end
    if (!acc_open || d != acc_dose) begin
      acc_dose = d; acc_n = 0; acc_sum = 0; acc_sq = 0; acc_ovf = 0; acc_open = 1;
    end
    add_obs(resp);
    if (last) begin
      stat_q.push_back(close_group(1));
      k++;
      acc_dose = 0; acc_n = 0; acc_sum = 0; acc_sq = 0; acc_ovf = 0; acc_open = 0;
    end
    return k;
  endfunction

  task automatic send(logic [31:0] d, logic [RespW-1:0] resp, logic last,
                      bit typed = 0, group_stat_t st = '0);
    int gap, k;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    dose_i <= d;
    response_i <= resp;
    last_item_i <= last;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    k = predict(d, resp, last);
    if (typed && k == 1) stat_q[$] = st;
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (stat_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // result side
  initial begin
    int gap;
    group_stat_t got, want;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(negedge clk_i);
      while (empty) @(negedge clk_i);
      got = '{group_dose_o, group_count_o, group_mean_o, group_std_dev_o,
              std_valid_o, count_overflow_o, last_group_o};
      if (stat_q.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, got);
        errors++;
      end else begin
        want = stat_q.pop_front();
        if (got.dose != want.dose || got.count != want.count || got.mean != want.mean ||
            got.std_dev != want.std_dev || got.std_valid != want.std_valid ||
            got.overflow != want.overflow || got.last != want.last) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  obs_row_t rows[$];
  logic [31:0] dsets[8];

  initial begin
    logic [31:0] d;
    logic [RespW-1:0] resp;
    int n, sent;
    bit lst;
    rows = '{
      '{32'h0, 16'h7fff, 1, 1, '{32'h0, 13'd1, 16'h7fff, 16'h0, 0, 0, 1}},
      '{32'hffffffff, 16'h8000, 1, 1, '{32'hffffffff, 13'd1, 16'h8000, 16'h0, 0, 0, 1}},
      '{32'h1, 16'h0100, 0, 0, '0},
      '{32'h1, 16'h0300, 1, 0, '0},
      '{32'h2, 16'h8000, 0, 0, '0},
      '{32'h2, 16'h8000, 0, 0, '0},
      '{32'h2, 16'h8000, 1, 1, '{32'h2, 13'd3, 16'h8000, 16'h0, 1, 0, 1}},
      '{32'h3, 16'h7fff, 0, 0, '0},
      '{32'h3, 16'h8000, 0, 0, '0},
      '{32'h4, 16'h1234, 1, 0, '0},
      '{32'haaaaaaaa, 16'h5555, 0, 0, '0},
      '{32'h55555555, 16'haaaa, 0, 0, '0},
      '{32'h55555555, 16'h0001, 0, 0, '0},
      '{32'h55555555, 16'hffff, 0, 0, '0},
      '{32'haaaaaaaa, 16'h0000, 0, 0, '0},
      '{32'haaaaaaaa, 16'h7fff, 0, 0, '0},
      '{32'haaaaaaaa, 16'h7fff, 1, 0, '0},
      '{32'h7, 16'hffff, 0, 0, '0},
      '{32'h7, 16'hffff, 1, 1, '{32'h7, 13'd2, 16'hffff, 16'h0, 1, 0, 1}}
    };
    acc_open = 0; acc_n = 0; acc_sum = 0; acc_sq = 0; acc_ovf = 0; acc_dose = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send(rows[i].dose, rows[i].resp, rows[i].last, rows[i].typed, rows[i].stat);
    drain();

    // full-size group, then one that runs four past the limit
    tx_burst = 1;
    for (int i = 0; i < MaxGroup; i++) send(32'h100, 16'($urandom), i == MaxGroup - 1);
    for (int i = 0; i < MaxGroup + 4; i++) send(32'h200, 16'h8000, i == MaxGroup + 3);
    tx_burst = 0;

    foreach (dsets[i]) dsets[i] = $urandom;
    d = '0;
    sent = 0;
    while (sent < 1700) begin
      if ($urandom_range(0, 99) < 3) begin
        tx_burst = ~tx_burst;
        rx_burst = $urandom_range(0, 2) == 0;
      end
      if (sent > 800 && sent < 830) drain();
      case ($urandom_range(0, 3))
        0: d = dsets[$urandom_range(0, 7)];
        1: d = d + 1;
        default: d = $urandom;
      endcase
      n = $urandom_range(0, 9) == 0 ? $urandom_range(15, 40) : $urandom_range(1, 6);
      lst = $urandom_range(0, 7) == 0;
      for (int j = 0; j < n; j++) begin
        case ($urandom_range(0, 3))
          0: resp = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          1: resp = 16'($signed($urandom_range(0, 600)) - 300);
          default: resp = $urandom;
        endcase
        if ($urandom_range(0, 63) == 0) d = $urandom;
        send(d, resp, lst && j == n - 1);
        sent++;
      end
    end
    send(d, 16'h0, 1);
    rx_burst = 0;
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
